// File: src/vcgm_pkg.sv
package vcgm_pkg;

  localparam int VTX_W   = 12;
  localparam int COVER_W = 10;

  typedef enum logic {
    FUNC_EDGE  = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_t;

endpackage

// File: src/vcgm_if.sv
interface vcgm_in_if import vcgm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [VTX_W-1:0] edge_u;
  logic [VTX_W-1:0] edge_v;

  modport source (output valid, output func, output edge_u, output edge_v, input ready);
  modport sink   (input valid, input func, input edge_u, input edge_v, output ready);
endinterface

interface vcgm_out_if import vcgm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COVER_W-1:0] cover_vertex;
  logic               bad_edge;
  logic               last_of_run;

  modport source (output valid, output cover_vertex, output bad_edge, output last_of_run,
                  input ready);
  modport sink   (input valid, input cover_vertex, input bad_edge, input last_of_run,
                  output ready);
endinterface

// File: src/vcgm_ram.sv
module vcgm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/vertex_cover_greedy_matching_top.sv
// channel   dir  handshake            word
// in_ch     in   in_ch.valid/ready    func, edge_u, edge_v
// out_ch    out  out_ch.valid/ready   cover_vertex, bad_edge, last_of_run
//
// edge word: read u, read v, check, write v of a matched pair (skipped when u == v),
//   then its result words; an edge with an end already covered gives no result word
// out-of-range edge: its result word is valid in the cycle after accept
// clear word and reset: a clearing pass over every entry of the cover map,
//   one entry per cycle through its single write port; in_ch.ready stays low meanwhile
// a stalled out_ch holds the result word and keeps in_ch.ready low
module vertex_cover_greedy_matching_top import vcgm_pkg::*; #(
  parameter int NUM_VERTICES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  vcgm_in_if.sink    in_ch,
  vcgm_out_if.source out_ch
);

  localparam int AW    = $clog2(NUM_VERTICES);
  localparam int CMP_W = VTX_W + 1;

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_CLR        = 8'b0000_0010,
    ST_RD_U       = 8'b0000_0100,
    ST_RD_V       = 8'b0000_1000,
    ST_CHK        = 8'b0001_0000,
    ST_WR_V       = 8'b0010_0000,
    ST_SEND_FIRST = 8'b0100_0000,
    ST_SEND_LAST  = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [VTX_W-1:0]   u_r, u_nxt;
  logic [VTX_W-1:0]   v_r, v_nxt;
  logic               cov_u_r, cov_u_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [COVER_W-1:0] out_vertex_r, out_vertex_nxt;
  logic               out_bad_r, out_bad_nxt;
  logic               out_last_r, out_last_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [0:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [0:0]    ram_rdata;
  logic          in_fire;
  logic          in_bad;

  vcgm_ram #(
    .WIDTH (1),
    .DEPTH (NUM_VERTICES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign in_bad              = ({1'b0, in_ch.edge_u} >= CMP_W'(NUM_VERTICES)) ||
                               ({1'b0, in_ch.edge_v} >= CMP_W'(NUM_VERTICES));
  assign out_ch.valid        = (state_r == ST_SEND_FIRST) || (state_r == ST_SEND_LAST);
  assign out_ch.cover_vertex = out_vertex_r;
  assign out_ch.bad_edge     = out_bad_r;
  assign out_ch.last_of_run  = out_last_r;

  assign ram_raddr = (state_r == ST_RD_U) ? u_r[AW-1:0] : v_r[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    cov_u_nxt      = cov_u_r;
    clr_addr_nxt   = clr_addr_r;
    out_vertex_nxt = out_vertex_r;
    out_bad_nxt    = out_bad_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = u_r[AW-1:0];
    ram_wdata      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          u_nxt = in_ch.edge_u;
          v_nxt = in_ch.edge_v;
          if (func_t'(in_ch.func) == FUNC_CLEAR) begin
            clr_addr_nxt = '0;
            state_nxt    = ST_CLR;
          end else if (in_bad) begin
            out_vertex_nxt = '0;
            out_bad_nxt    = 1'b1;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_SEND_LAST;
          end else begin
            state_nxt = ST_RD_U;
          end
        end
      end
      ST_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NUM_VERTICES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_U: begin
        state_nxt = ST_RD_V;
      end
      ST_RD_V: begin
        cov_u_nxt = ram_rdata[0];
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (cov_u_r || ram_rdata[0]) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = u_r[AW-1:0];
          out_vertex_nxt = u_r[COVER_W-1:0];
          out_bad_nxt    = 1'b0;
          if (u_r == v_r) begin
            out_last_nxt = 1'b1;
            state_nxt    = ST_SEND_LAST;
          end else begin
            out_last_nxt = 1'b0;
            state_nxt    = ST_WR_V;
          end
        end
      end
      ST_WR_V: begin
        ram_we    = 1'b1;
        ram_waddr = v_r[AW-1:0];
        state_nxt = ST_SEND_FIRST;
      end
      ST_SEND_FIRST: begin
        if (out_ch.ready) begin
          out_vertex_nxt = v_r[COVER_W-1:0];
          out_last_nxt   = 1'b1;
          state_nxt      = ST_SEND_LAST;
        end
      end
      ST_SEND_LAST: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    cov_u_r      <= cov_u_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_bad_r    <= out_bad_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// File: src/vcgm_checker.sv
module vcgm_checker import vcgm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COVER_W-1:0] out_cover_vertex,
  input logic               out_bad_edge,
  input logic               out_last_of_run
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid) && !$past(out_ready) |->
      out_valid && $stable(out_cover_vertex) && $stable(out_bad_edge) &&
      $stable(out_last_of_run))
    else $error("result word changed while stalled");

  // a dropped edge reports vertex zero and closes its run
  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_edge |-> out_last_of_run && (out_cover_vertex == '0))
    else $error("bad edge word malformed");

  // one word at a time: no input taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // first vertex of a matched edge is followed at once by the closing vertex
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=>
      out_valid && out_last_of_run && !out_bad_edge)
    else $error("second vertex of matched edge missing");

  // an accepted word makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

endmodule

bind vertex_cover_greedy_matching_top vcgm_checker u_vcgm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_cover_vertex (out_ch.cover_vertex),
  .out_bad_edge     (out_ch.bad_edge),
  .out_last_of_run  (out_ch.last_of_run)
);
